// ===== hdl/hba_pkg.sv =====
package hba_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int REC_BITS    = SAMPLE_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int STEP_BITS   = 3;
    localparam int KEY_BITS    = 2;
    localparam int IDX_BITS    = 3;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [STEP_BITS-1:0] STEP_JUDGE_REC = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_JUDGE_ERR = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_RECORD    = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_READJUST  = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_REPORT    = 3'd4;

    localparam logic [KEY_BITS-1:0] KEY_MEDIA = 2'd0;
    localparam logic [KEY_BITS-1:0] KEY_UP    = 2'd1;
    localparam logic [KEY_BITS-1:0] KEY_DOWN  = 2'd2;
    localparam logic [KEY_BITS-1:0] KEY_NONE  = 2'd3;

    localparam logic [KEY_BITS-1:0] CODE_KEEP = 2'd0;
    localparam logic [KEY_BITS-1:0] CODE_UP   = 2'd1;
    localparam logic [KEY_BITS-1:0] CODE_DOWN = 2'd2;

    localparam logic [IDX_BITS-1:0] REG_ENABLE        = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_MEDIA_MIN     = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_MEDIA_MAX     = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_UP_MIN        = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_UP_MAX_INIT   = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_DOWN_MIN_INIT = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_DOWN_MAX      = 3'd6;

    localparam logic [SAMPLE_BITS-1:0] DEF_MARGIN        = SAMPLE_BITS'(35);
    localparam logic [SAMPLE_BITS-1:0] RST_MEDIA_MIN     = SAMPLE_BITS'(0);
    localparam logic [SAMPLE_BITS-1:0] RST_MEDIA_MAX     = SAMPLE_BITS'(100);
    localparam logic [SAMPLE_BITS-1:0] RST_UP_MIN        = SAMPLE_BITS'(101);
    localparam logic [SAMPLE_BITS-1:0] RST_UP_MAX_INIT   = SAMPLE_BITS'(250);
    localparam logic [SAMPLE_BITS-1:0] RST_DOWN_MIN_INIT = SAMPLE_BITS'(251);
    localparam logic [SAMPLE_BITS-1:0] RST_DOWN_MAX      = SAMPLE_BITS'(500);
    localparam logic signed [REC_BITS-1:0] NO_RECORD     = -REC_BITS'(1);

    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_UP    = 2'd1,
        PH_BOTH  = 2'd2
    } t_phase;

    typedef struct packed {
        logic                   action;
        logic [STEP_BITS-1:0]   entry_state;
        logic [SAMPLE_BITS-1:0] voltage;
    } t_in_item;

    typedef struct packed {
        logic                reported;
        logic [KEY_BITS-1:0] pressed_key;
        logic [KEY_BITS-1:0] report_code;
    } t_out_item;

    typedef struct packed {
        logic                   we;
        logic [IDX_BITS-1:0]    idx;
        logic [SAMPLE_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                   enable;
        logic [SAMPLE_BITS-1:0] media_min;
        logic [SAMPLE_BITS-1:0] media_max;
        logic [SAMPLE_BITS-1:0] up_min;
        logic [SAMPLE_BITS-1:0] down_max;
    } t_cfg;

endpackage

// ===== hdl/headset_button_autocalib.sv =====
// Headset button auto-calibration.
// Input channel: i_valid / o_stall with payload i_data (action, entry_state,
// voltage). A transaction is taken at a rising edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with payload o_data
// (reported, pressed_key, report_code), one result per input transaction.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; a write takes effect at the
// edge where i_cfg_we is high. Write only while no transaction is in flight.
// An accepted transaction is held in the input register; its result is formed
// combinationally and loaded into the output register, which drives o_valid.
// Throughput: one transaction per cycle unless i_stall holds a result; the
// learn, readjust and classify path between the registers is combinational.
// Stall: while i_stall holds a result, the output register and input
// register both hold and o_stall rises once the input register is occupied.
// Reset (synchronous, i_rst_n low): both registers empty, configuration back
// to defaults, learned records, margins and span back to their start values.
module headset_button_autocalib (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  hba_pkg::t_in_item                   i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output hba_pkg::t_out_item                  o_data,
    input  logic                                i_cfg_we,
    input  logic [hba_pkg::IDX_BITS-1:0]        i_cfg_idx,
    input  logic [hba_pkg::SAMPLE_BITS-1:0]     i_cfg_data
);

    logic               r_in_valid, n_in_valid;
    hba_pkg::t_in_item  r_in;
    logic               r_out_valid, n_out_valid;
    hba_pkg::t_out_item r_out;
    logic               advance, fire, accept;
    hba_pkg::t_cfg_wr   cfg_wr;
    hba_pkg::t_cfg      cfg;
    hba_pkg::t_out_item result;

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid  = accept ? 1'b1 : (fire ? 1'b0 : r_in_valid);
        n_out_valid = advance ? fire : r_out_valid;
    end

    hba_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .o_cfg    (cfg)
    );

    hba_calib u_calib (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_cfg_wr (cfg_wr),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hdl/hba_cfg.sv =====
module hba_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hba_pkg::t_cfg_wr i_cfg_wr,
    output hba_pkg::t_cfg    o_cfg
);

    hba_pkg::t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr.we) begin
            unique case (i_cfg_wr.idx)
                hba_pkg::REG_ENABLE:    n_cfg.enable    = i_cfg_wr.data[0];
                hba_pkg::REG_MEDIA_MIN: n_cfg.media_min = i_cfg_wr.data;
                hba_pkg::REG_MEDIA_MAX: n_cfg.media_max = i_cfg_wr.data;
                hba_pkg::REG_UP_MIN:    n_cfg.up_min    = i_cfg_wr.data;
                hba_pkg::REG_DOWN_MAX:  n_cfg.down_max  = i_cfg_wr.data;
                default:                n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.media_min <= hba_pkg::RST_MEDIA_MIN;
            r_cfg.media_max <= hba_pkg::RST_MEDIA_MAX;
            r_cfg.up_min    <= hba_pkg::RST_UP_MIN;
            r_cfg.down_max  <= hba_pkg::RST_DOWN_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/hba_calib.sv =====
module hba_calib (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  hba_pkg::t_in_item  i_item,
    input  hba_pkg::t_cfg      i_cfg,
    input  hba_pkg::t_cfg_wr   i_cfg_wr,
    output hba_pkg::t_out_item o_result
);

    localparam int SB = hba_pkg::SAMPLE_BITS;
    localparam int RB = hba_pkg::REC_BITS;
    localparam int DB = hba_pkg::SUM_BITS;

    logic signed [RB-1:0] r_up_rec, n_up_rec, r_dn_rec, n_dn_rec;
    logic [SB-1:0]        r_up_margin, n_up_margin, r_dn_margin, n_dn_margin;
    logic [SB-1:0]        r_span, n_span;
    logic [SB-1:0]        r_up_work, n_up_work, r_dn_work, n_dn_work;
    hba_pkg::t_phase      r_phase, n_phase;

    logic signed [RB-1:0] c_up_rec, c_dn_rec;
    hba_pkg::t_phase      c_phase;
    logic signed [DB-1:0] v_s, up_s, dn_s, d_up, d_dn, a_up, a_dn;
    logic signed [DB-1:0] gap, mg_diff, sum_s;
    logic [SB-1:0]        volt, new_span, half, mid, c_up_work, c_dn_work;
    logic                 ignore, near, do_rec, rec_ok, do_marg, do_adj;
    logic [hba_pkg::KEY_BITS-1:0] key, code;

    always_comb begin
        volt = i_item.voltage;
        v_s  = $signed({2'b00, volt});
        up_s = DB'(r_up_rec);
        dn_s = DB'(r_dn_rec);
        d_up = v_s - up_s;
        d_dn = v_s - dn_s;
        a_up = (d_up < 0) ? -d_up : d_up;
        a_dn = (d_dn < 0) ? -d_dn : d_dn;
        near = ((r_phase != hba_pkg::PH_EMPTY) && (a_up < $signed({2'b00, r_up_margin})))
            || ((r_phase == hba_pkg::PH_BOTH) && (a_dn < $signed({2'b00, r_dn_margin})));

        ignore = (i_item.action == hba_pkg::ACT_CLEAR) || !i_cfg.enable
            || (volt > i_cfg.down_max) || (i_item.entry_state > hba_pkg::STEP_REPORT);

        unique case (i_item.entry_state)
            hba_pkg::STEP_JUDGE_REC: do_rec = (r_phase == hba_pkg::PH_EMPTY) || !near;
            hba_pkg::STEP_JUDGE_ERR: do_rec = !near;
            hba_pkg::STEP_RECORD:    do_rec = 1'b1;
            default:                 do_rec = 1'b0;
        endcase

        // record step
        rec_ok   = volt >= i_cfg.media_max;
        c_up_rec = r_up_rec;
        c_dn_rec = r_dn_rec;
        c_phase  = r_phase;
        do_marg  = 1'b0;
        if (do_rec && rec_ok) begin
            unique case (r_phase)
                hba_pkg::PH_EMPTY: begin
                    c_up_rec = $signed({1'b0, volt});
                    c_phase  = hba_pkg::PH_UP;
                end
                hba_pkg::PH_UP: begin
                    if (v_s > up_s) begin
                        c_dn_rec = $signed({1'b0, volt});
                    end else begin
                        c_dn_rec = r_up_rec;
                        c_up_rec = $signed({1'b0, volt});
                    end
                    c_phase = hba_pkg::PH_BOTH;
                    do_marg = 1'b1;
                end
                default: begin
                    if (v_s < up_s) begin
                        c_up_rec = $signed({1'b0, volt});
                    end else if (v_s > dn_s) begin
                        c_dn_rec = $signed({1'b0, volt});
                    end
                    do_marg = 1'b1;
                end
            endcase
        end

        // margin update
        gap      = DB'(c_dn_rec) - DB'(c_up_rec);
        new_span = (gap > $signed({2'b00, r_span})) ? gap[SB-1:0] : r_span;
        half     = {1'b0, new_span[SB-1:1]};
        mg_diff  = DB'(c_up_rec) - $signed({2'b00, i_cfg.media_max});
        if ((mg_diff >= 0) && (mg_diff[SB:1] < half)) begin
            half = mg_diff[SB:1];
        end

        // boundary readjust
        do_adj    = do_rec ? (c_phase == hba_pkg::PH_BOTH)
                           : (i_item.entry_state == hba_pkg::STEP_READJUST);
        sum_s     = DB'(c_up_rec) + DB'(c_dn_rec);
        mid       = sum_s[SB:1];
        c_up_work = do_adj ? mid : r_up_work;
        c_dn_work = !do_adj ? r_dn_work : ((&mid) ? mid : mid + SB'(1));

        // next state
        n_up_rec    = r_up_rec;
        n_dn_rec    = r_dn_rec;
        n_up_margin = r_up_margin;
        n_dn_margin = r_dn_margin;
        n_span      = r_span;
        n_phase     = r_phase;
        n_up_work   = r_up_work;
        n_dn_work   = r_dn_work;
        if (i_fire) begin
            if (i_item.action == hba_pkg::ACT_CLEAR) begin
                n_up_rec    = hba_pkg::NO_RECORD;
                n_dn_rec    = hba_pkg::NO_RECORD;
                n_up_margin = hba_pkg::DEF_MARGIN;
                n_dn_margin = hba_pkg::DEF_MARGIN;
                n_phase     = hba_pkg::PH_EMPTY;
            end else if (!ignore) begin
                n_up_rec  = c_up_rec;
                n_dn_rec  = c_dn_rec;
                n_phase   = c_phase;
                n_up_work = c_up_work;
                n_dn_work = c_dn_work;
                if (do_marg) begin
                    n_span      = new_span;
                    n_up_margin = half;
                    n_dn_margin = new_span - half;
                end
            end
        end
        if (i_cfg_wr.we && (i_cfg_wr.idx == hba_pkg::REG_UP_MAX_INIT)) begin
            n_up_work = i_cfg_wr.data;
        end
        if (i_cfg_wr.we && (i_cfg_wr.idx == hba_pkg::REG_DOWN_MIN_INIT)) begin
            n_dn_work = i_cfg_wr.data;
        end

        // classify
        priority if ((volt >= i_cfg.media_min) && (volt <= i_cfg.media_max)) begin
            key  = hba_pkg::KEY_MEDIA;
            code = hba_pkg::CODE_KEEP;
        end else if ((volt >= i_cfg.up_min) && (volt <= c_up_work)) begin
            key  = hba_pkg::KEY_UP;
            code = hba_pkg::CODE_UP;
        end else if ((volt >= c_dn_work) && (volt <= i_cfg.down_max)) begin
            key  = hba_pkg::KEY_DOWN;
            code = hba_pkg::CODE_DOWN;
        end else begin
            key  = hba_pkg::KEY_NONE;
            code = hba_pkg::CODE_KEEP;
        end

        o_result.reported    = !ignore;
        o_result.pressed_key = ignore ? hba_pkg::KEY_NONE : key;
        o_result.report_code = ignore ? hba_pkg::CODE_KEEP : code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_rec    <= hba_pkg::NO_RECORD;
            r_dn_rec    <= hba_pkg::NO_RECORD;
            r_up_margin <= hba_pkg::DEF_MARGIN;
            r_dn_margin <= hba_pkg::DEF_MARGIN;
            r_span      <= hba_pkg::DEF_MARGIN;
            r_phase     <= hba_pkg::PH_EMPTY;
            r_up_work   <= hba_pkg::RST_UP_MAX_INIT;
            r_dn_work   <= hba_pkg::RST_DOWN_MIN_INIT;
        end else begin
            r_up_rec    <= n_up_rec;
            r_dn_rec    <= n_dn_rec;
            r_up_margin <= n_up_margin;
            r_dn_margin <= n_dn_margin;
            r_span      <= n_span;
            r_phase     <= n_phase;
            r_up_work   <= n_up_work;
            r_dn_work   <= n_dn_work;
        end
    end

    a_rec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hba_pkg::PH_BOTH) |-> (r_dn_rec >= r_up_rec))
        else $error("down record below up record");

    a_up_learned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != hba_pkg::PH_EMPTY) |-> (r_up_rec >= 0))
        else $error("up record empty after learning");

    a_margin_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hba_pkg::PH_BOTH)
        |-> (({1'b0, r_up_margin} + {1'b0, r_dn_margin}) == {1'b0, r_span}))
        else $error("margins do not add up to span");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.action == hba_pkg::ACT_CLEAR)) |=> (r_phase == hba_pkg::PH_EMPTY))
        else $error("clear transaction left learned state");

endmodule
